>>> hdl/hwt_pkg.sv
// Shared types, constants and helper functions of the hillshade water-tint pixel shader.
package hwt_pkg;

    // Field widths
    localparam int COL_W   = 4;
    localparam int CHAN_W  = 8;
    localparam int H_W     = 9;
    localparam int Q_W     = 18;
    localparam int M_W     = 11;
    localparam int K_W     = 10;
    localparam int COLS    = 1 << COL_W;

    // Default tile width
    localparam int TILE_WIDTH_DEF = 16;

    // Q10 fixed-point constants
    localparam int Q_ONE      = 1024;
    localparam int K_MAX      = 901;
    localparam int K_BASE     = 430;
    localparam int K_STEP     = 56;
    localparam int FADE_STEP  = 20;
    localparam int SHADE_STEP = 71;
    localparam int SHADE_MIN  = 737;
    localparam int SHADE_MAX  = 1249;
    localparam int CHAN_MAX   = 255;

    // Configuration register indexes (word address paddr[3:2])
    localparam int APB_AW = 4;
    typedef enum logic [1:0] {
        REG_WATER_RED   = 2'd0,
        REG_WATER_GREEN = 2'd1,
        REG_WATER_BLUE  = 2'd2
    } t_reg_idx;

    // Command codes
    localparam logic CMD_PRIME = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // Water tint colour
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_tint;

    // One accepted pixel request
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [H_W-1:0]    h;
        logic [CHAN_W-1:0] depth;
    } t_pix;

    // One shaded result
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_res;

    // Column to memory entry map, one byte per column
    typedef logic [COLS-1:0][7:0] t_col_map;

    // Builds the column-modulo-width map at elaboration by repeated subtraction
    function automatic t_col_map col_map(input int tw);
        t_col_map m;
        int       v;
        for (int c = 0; c < COLS; c++) begin
            v = c;
            for (int j = 0; j < COLS; j++) begin
                if (v >= tw) v = v - tw;
            end
            m[c] = 8'(v);
        end
        return m;
    endfunction

endpackage

>>> hdl/hwt_cfg.sv
// APB register block holding the water tint colour.
module hwt_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hwt_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output hwt_pkg::t_tint            o_tint
);
    import hwt_pkg::*;

    t_tint    r_tint;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_tint = r_tint;

    // Register writes; unmapped addresses are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WATER_RED:   r_tint.red   <= pwdata[CHAN_W-1:0];
                REG_WATER_GREEN: r_tint.green <= pwdata[CHAN_W-1:0];
                REG_WATER_BLUE:  r_tint.blue  <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_WATER_RED:   prdata = 32'(r_tint.red);
            REG_WATER_GREEN: prdata = 32'(r_tint.green);
            REG_WATER_BLUE:  prdata = 32'(r_tint.blue);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> hdl/hwt_hmem.sv
// North height memory: read-first single port, one read and write per request.
module hwt_hmem #(
    parameter int TILE_WIDTH = hwt_pkg::TILE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [hwt_pkg::COL_W-1:0] i_col,
    input  logic [hwt_pkg::H_W-1:0]   i_h,
    output logic [hwt_pkg::H_W-1:0]   o_north
);
    import hwt_pkg::*;

    localparam int       IDX_W   = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
    localparam t_col_map COL_MAP = col_map(TILE_WIDTH);

    logic [H_W-1:0]        r_mem [TILE_WIDTH];
    logic [TILE_WIDTH-1:0] r_vld;
    logic [H_W-1:0]        r_rd;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      w_idx;

    assign w_idx = COL_MAP[i_col][IDX_W-1:0];

    // Old value read out, new height written back at the same entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rd         <= r_mem[w_idx];
            r_mem[w_idx] <= i_h;
        end
    end

    // Entry valid bits stand in for the zero reset of the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_we) begin
            r_rd_vld     <= r_vld[w_idx];
            r_vld[w_idx] <= 1'b1;
        end
    end

    assign o_north = r_rd_vld ? r_rd : '0;

endmodule

>>> hdl/hwt_pipe.sv
// Shading datapath: tint, fade and hillshade stages followed by an output register and skid.
module hwt_pipe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  hwt_pkg::t_pix           i_pix,
    input  logic [hwt_pkg::H_W-1:0] i_north,
    input  hwt_pkg::t_tint          i_tint,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_ready,
    output hwt_pkg::t_res           o_res
);
    import hwt_pkg::*;

    logic w_en;

    // Stage 1: request, aligned with the memory read data
    logic r1_v;
    t_pix r1_pix;

    // Stage 2: blend weights and shade factor
    logic                 r2_v;
    logic [COL_W-1:0]     r2_col;
    logic [CHAN_W-1:0]    r2_r, r2_g, r2_b;
    logic [K_W-1:0]       r2_k;
    logic [M_W-1:0]       r2_fade, r2_inv, r2_m;
    logic signed [9:0]    w_dh;
    logic signed [17:0]   w_mraw;
    logic [M_W-1:0]       w_m;
    logic [14:0]          w_kraw;
    logic [K_W-1:0]       w_k;
    logic [12:0]          w_fd;
    logic [M_W-1:0]       w_fade;

    // Stage 3: partial products
    logic                 r3_v;
    logic [COL_W-1:0]     r3_col;
    logic [Q_W-1:0]       r3_pr, r3_pg, r3_pb, r3_wr, r3_wg, r3_wb;
    logic [M_W-1:0]       r3_fade, r3_m;

    // Stage 4: channel values in Q10
    logic                 r4_v;
    logic [COL_W-1:0]     r4_col;
    logic [Q_W-1:0]       r4_qr, r4_qg, r4_qb;
    logic [M_W-1:0]       r4_m;
    logic [28:0]          w_tr, w_tg;

    // Output side
    logic                 r_ovalid, r_svalid;
    t_res                 r_ores, r_sres, w_res;
    logic [28:0]          w_sr, w_sg, w_sb;
    logic                 w_take;

    assign w_en    = !r_svalid;
    assign o_ready = w_en;

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= i_load;
    end
    always_ff @(posedge i_clk) begin
        if (w_en && i_load) r1_pix <= i_pix;
    end

    // Height step, shade factor, blend weight and fade
    always_comb begin
        w_dh   = $signed({1'b0, r1_pix.h}) - $signed({1'b0, i_north});
        w_mraw = $signed(18'(Q_ONE)) + $signed(18'(w_dh)) * $signed(18'(SHADE_STEP));
        if (w_mraw < $signed(18'(SHADE_MIN)))      w_m = M_W'(SHADE_MIN);
        else if (w_mraw > $signed(18'(SHADE_MAX))) w_m = M_W'(SHADE_MAX);
        else                                       w_m = w_mraw[M_W-1:0];

        w_kraw = 15'(K_BASE) + 15'(K_STEP) * 15'(r1_pix.depth);
        if (r1_pix.depth == '0)        w_k = '0;
        else if (w_kraw > 15'(K_MAX))  w_k = K_W'(K_MAX);
        else                           w_k = w_kraw[K_W-1:0];

        w_fd = 13'(FADE_STEP) * 13'(r1_pix.depth);
        if (w_fd >= 13'(Q_ONE)) w_fade = '0;
        else                    w_fade = M_W'(13'(Q_ONE) - w_fd);
    end

    // Stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_col  <= r1_pix.col;
            r2_r    <= r1_pix.red;
            r2_g    <= r1_pix.green;
            r2_b    <= r1_pix.blue;
            r2_k    <= w_k;
            r2_inv  <= M_W'(Q_ONE) - M_W'(w_k);
            r2_fade <= w_fade;
            r2_m    <= w_m;
        end
    end

    // Stage 3: base and water products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_col  <= r2_col;
            r3_pr   <= Q_W'(r2_r) * Q_W'(r2_inv);
            r3_pg   <= Q_W'(r2_g) * Q_W'(r2_inv);
            r3_pb   <= Q_W'(r2_b) * Q_W'(r2_inv);
            r3_wr   <= Q_W'(i_tint.red) * Q_W'(r2_k);
            r3_wg   <= Q_W'(i_tint.green) * Q_W'(r2_k);
            r3_wb   <= Q_W'(i_tint.blue) * Q_W'(r2_k);
            r3_fade <= r2_fade;
            r3_m    <= r2_m;
        end
    end

    // Fade applies to red and green only
    assign w_tr = 29'(r3_wr) * 29'(r3_fade);
    assign w_tg = 29'(r3_wg) * 29'(r3_fade);

    // Stage 4: channel sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_col <= r3_col;
            r4_qr  <= r3_pr + w_tr[27:10];
            r4_qg  <= r3_pg + w_tg[27:10];
            r4_qb  <= r3_pb + r3_wb;
            r4_m   <= r3_m;
        end
    end

    // Hillshade scale and saturation
    always_comb begin
        w_sr      = 29'(r4_qr) * 29'(r4_m);
        w_sg      = 29'(r4_qg) * 29'(r4_m);
        w_sb      = 29'(r4_qb) * 29'(r4_m);
        w_res.col = r4_col;
        w_res.red   = w_sr[28] ? CHAN_W'(CHAN_MAX) : w_sr[27:20];
        w_res.green = w_sg[28] ? CHAN_W'(CHAN_MAX) : w_sg[27:20];
        w_res.blue  = w_sb[28] ? CHAN_W'(CHAN_MAX) : w_sb[27:20];
    end

    // Output register with one-entry skid; the pipeline freezes while the skid is full
    assign w_take = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (w_take) begin
            if (r_svalid) begin
                r_ovalid <= 1'b1;
                r_svalid <= 1'b0;
            end else begin
                r_ovalid <= r4_v;
            end
        end else if (w_en && r4_v) begin
            r_svalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ores <= r_svalid ? r_sres : w_res;
        end else if (w_en && r4_v) begin
            r_sres <= w_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_ores;

endmodule

>>> hdl/hillshade_water_tint_pixel_top.sv
// Top level of the hillshade water-tint pixel shader.
//
// Input stream (s_axis): one request per accepted beat. tuser is the command
// (0 primes the north height of a column, 1 shades a pixel); tdata carries the
// column, base colour, ground height and water depth. Prime requests give no
// result; each shade request gives one result on the output stream (m_axis)
// with the echoed column and the shaded colour, in request order.
// Configuration: APB registers water_red, water_green and water_blue at byte
// addresses 0, 4 and 8; write them only while the block is idle.
// Throughput: one request per clock while the skid is empty. The north
// heights sit in a read-first memory that is read and rewritten in the cycle
// a request is accepted, so requests to the same column may follow each other
// directly. A result passes through the memory read, weight stage, product
// stage, sum stage and output register before it is offered.
// When the receiver stalls, a one-entry skid catches the result in flight and
// s_axis_tready drops until the output drains; nothing is lost.
// Reset clears the tint registers, marks every north height as zero and
// empties the pipeline.
module hillshade_water_tint_pixel_top #(
    parameter int TILE_WIDTH = hwt_pkg::TILE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // {water_depth, ground_height, base_blue, base_green, base_red, column}, zero padded
    input  logic [47:0]                i_s_axis_tdata,
    // {command}
    input  logic                       i_s_axis_tuser,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // {out_blue, out_green, out_red, out_column}, zero padded
    output logic [31:0]                o_m_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hwt_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import hwt_pkg::*;

    t_tint          w_tint;
    t_pix           w_pix;
    t_res           w_res;
    logic           w_accept;
    logic           w_ready;
    logic [H_W-1:0] w_north;

    // Unpack the request
    always_comb begin
        w_pix.col   = i_s_axis_tdata[3:0];
        w_pix.red   = i_s_axis_tdata[11:4];
        w_pix.green = i_s_axis_tdata[19:12];
        w_pix.blue  = i_s_axis_tdata[27:20];
        w_pix.depth = i_s_axis_tdata[43:36];
        w_pix.h     = H_W'(i_s_axis_tdata[35:28]) + H_W'(i_s_axis_tdata[43:36]);
    end

    assign o_s_axis_tready = w_ready;
    assign w_accept        = i_s_axis_tvalid && w_ready;

    hwt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tint  (w_tint)
    );

    hwt_hmem #(
        .TILE_WIDTH (TILE_WIDTH)
    ) u_hmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_accept),
        .i_col   (w_pix.col),
        .i_h     (w_pix.h),
        .o_north (w_north)
    );

    hwt_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && (i_s_axis_tuser == CMD_SHADE)),
        .i_pix   (w_pix),
        .i_north (w_north),
        .i_tint  (w_tint),
        .o_ready (w_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_res)
    );

    // Pack the result
    assign o_m_axis_tdata = {4'b0, w_res.blue, w_res.green, w_res.red, w_res.col};

endmodule
